// ===== hdl/ewmav_pkg.sv =====
package ewmav_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int EST_W       = 32;
   localparam int OPND_W      = 32;
   localparam int PROD_W      = 2 * OPND_W;
   localparam int ROOT_IN_W   = 64;
   localparam int ROOT_W      = ROOT_IN_W / 2;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int KIND_W      = 2;
   localparam int STEP_W      = 3;

   localparam logic [STEP_W-1:0] LAST_STEP = 3'd5;

   localparam logic [KIND_W-1:0] KIND_STDDEV   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VARIANCE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MEANABS  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KIND  = 2'd2;

   typedef enum logic [1:0] {OPA_PREV, OPA_MAG, OPA_TLO, OPA_THI} opa_type;
   typedef enum logic [1:0] {OPB_PREV, OPB_MAG, OPB_LAM, OPB_REST} opb_type;
   typedef enum logic [2:0] {WR_NONE, WR_TEMP, WR_ACC0, WR_ACC32, WR_ACCF} wr_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_WR, ST_ROOT_GO, ST_ROOT_WAIT, ST_DONE
   } state_type;

   typedef struct packed {
      opa_type opa;
      opb_type opb;
      wr_type  wr;
      logic    last;
   } uop_type;

   typedef struct packed {
      logic    load;
      logic    mul_en;
      opa_type opa;
      opb_type opb;
      wr_type  wr;
      logic    root_start;
      logic    finish;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              root_done;
   } sts_type;

   // Multiply program: one product per step, then where it goes.
   function automatic uop_type ewmav_uop(input logic [KIND_W-1:0] kind,
                                         input logic [STEP_W-1:0] step);
      uop_type u;
      u = '{OPA_PREV, OPB_LAM, WR_NONE, 1'b1};
      case (kind)
         KIND_STDDEV: begin
            case (step)
               3'd0: u = '{OPA_PREV, OPB_PREV, WR_TEMP,  1'b0};
               3'd1: u = '{OPA_TLO,  OPB_LAM,  WR_ACC0,  1'b0};
               3'd2: u = '{OPA_THI,  OPB_LAM,  WR_ACC32, 1'b0};
               3'd3: u = '{OPA_MAG,  OPB_MAG,  WR_TEMP,  1'b0};
               3'd4: u = '{OPA_TLO,  OPB_REST, WR_ACC0,  1'b0};
               3'd5: u = '{OPA_THI,  OPB_REST, WR_ACC32, 1'b1};
               default: u = '{OPA_PREV, OPB_LAM, WR_NONE, 1'b1};
            endcase
         end
         KIND_VARIANCE: begin
            case (step)
               3'd0: u = '{OPA_PREV, OPB_LAM,  WR_ACCF,  1'b0};
               3'd1: u = '{OPA_MAG,  OPB_MAG,  WR_TEMP,  1'b0};
               3'd2: u = '{OPA_TLO,  OPB_REST, WR_ACC0,  1'b0};
               3'd3: u = '{OPA_THI,  OPB_REST, WR_ACC32, 1'b1};
               default: u = '{OPA_PREV, OPB_LAM, WR_NONE, 1'b1};
            endcase
         end
         default: begin
            // mean absolute, also the unused code
            case (step)
               3'd0: u = '{OPA_PREV, OPB_LAM,  WR_ACC0, 1'b0};
               3'd1: u = '{OPA_MAG,  OPB_REST, WR_ACC0, 1'b1};
               default: u = '{OPA_PREV, OPB_LAM, WR_NONE, 1'b1};
            endcase
         end
      endcase
      return u;
   endfunction

endpackage

// ===== hdl/ewmav_req_if.sv =====
interface ewmav_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ewmav_pkg::SAMPLE_W-1:0] sample;
   logic                                end_of_series;

   modport source (output valid, output sample, output end_of_series, input ready);
   modport sink   (input valid, input sample, input end_of_series, output ready);
endinterface

// ===== hdl/ewmav_rsp_if.sv =====
interface ewmav_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ewmav_pkg::EST_W-1:0]  estimate;
   logic                         saturated;

   modport source (output valid, output estimate, output saturated, input ready);
   modport sink   (input valid, input estimate, input saturated, output ready);
endinterface

// ===== hdl/ewmav_isqrt.sv =====
module ewmav_isqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [ewmav_pkg::ROOT_IN_W-1:0]    radicand,
   output logic                               done,
   output logic [ewmav_pkg::ROOT_W-1:0]       root
);

   localparam int CNT_W = $clog2(ewmav_pkg::ROOT_W);
   localparam int XW    = ewmav_pkg::ROOT_IN_W;

   logic [XW-1:0]    x_ff, x_in;
   logic [XW-1:0]    res_ff, res_in;
   logic [XW-1:0]    bit_ff, bit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [XW-1:0]    trial;
   logic             last_iter;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   always_comb begin
      trial     = res_ff + bit_ff;
      last_iter = (cnt_ff == CNT_W'(ewmav_pkg::ROOT_W - 1));
      x_in      = x_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = busy_ff & last_iter;
      if (start) begin
         x_in    = radicand;
         res_in  = '0;
         bit_in  = XW'(1) << (XW - 2);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one result bit per cycle
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + CNT_W'(1);
         if (last_iter) begin
            busy_in = 1'b0;
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[ewmav_pkg::ROOT_W-1:0];

   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (res_ff[XW-1:ewmav_pkg::ROOT_W] == '0))
      else $error("square root wider than result");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff && $past(busy_ff)))
      else $error("root done without a finished pass");

endmodule

// ===== hdl/ewmav_datapath.sv =====
module ewmav_datapath #(
   parameter int SAMPLE_FRAC_BITS = 16,
   parameter int DECAY_FRAC_BITS  = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_we,
   input  logic [ewmav_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [ewmav_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic signed [ewmav_pkg::SAMPLE_W-1:0]    sample,
   input  logic                                     end_of_series,
   input  ewmav_pkg::cmd_type                       cmd,
   output ewmav_pkg::sts_type                       sts,
   output logic [ewmav_pkg::EST_W-1:0]              estimate,
   output logic                                     saturated
);

   localparam int LAM_W      = DECAY_FRAC_BITS + 1;
   localparam int ACC_W      = ewmav_pkg::PROD_W + DECAY_FRAC_BITS + 2;
   localparam int OW         = ewmav_pkg::OPND_W;
   localparam int PW         = ewmav_pkg::PROD_W;
   localparam int EW         = ewmav_pkg::EST_W;
   localparam int DECAY_RST  = (94 * (1 << DECAY_FRAC_BITS) + 50) / 100;
   localparam logic [LAM_W-1:0] DECAY_ONE = LAM_W'(1) << DECAY_FRAC_BITS;

   logic [LAM_W-1:0]                decay_ff, decay_in;
   logic [EW-1:0]                   seed_ff, seed_in;
   logic [ewmav_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [EW-1:0]                   prev_ff, prev_in;
   logic                            fresh_ff, fresh_in;

   logic [OW-1:0]                   p_ff, p_in;
   logic [OW-1:0]                   mag_ff, mag_in;
   logic                            eos_ff, eos_in;
   logic [PW-1:0]                   prod_ff, prod_in;
   logic [PW-1:0]                   temp_ff, temp_in;
   logic [ACC_W-1:0]                acc_ff, acc_in;
   logic [EW-1:0]                   est_ff, est_in;
   logic                            sat_ff, sat_in;

   logic [LAM_W-1:0]                lam;
   logic [LAM_W-1:0]                rest;
   logic [OW-1:0]                   raw;
   logic [OW-1:0]                   op_a;
   logic [OW-1:0]                   op_b;
   logic [ACC_W-1:0]                scaled_d;
   logic [ACC_W-1:0]                scaled_v;
   logic [ewmav_pkg::ROOT_W-1:0]    root;
   logic                            root_done;

   ewmav_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (scaled_d[ewmav_pkg::ROOT_IN_W-1:0]),
      .done     (root_done),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= LAM_W'(DECAY_RST);
         seed_ff  <= '0;
         kind_ff  <= ewmav_pkg::KIND_STDDEV;
         prev_ff  <= '0;
         fresh_ff <= 1'b1;
      end else begin
         decay_ff <= decay_in;
         seed_ff  <= seed_in;
         kind_ff  <= kind_in;
         prev_ff  <= prev_in;
         fresh_ff <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      mag_ff  <= mag_in;
      eos_ff  <= eos_in;
      prod_ff <= prod_in;
      temp_ff <= temp_in;
      acc_ff  <= acc_in;
      est_ff  <= est_in;
      sat_ff  <= sat_in;
   end

   // clamp lambda to one
   always_comb begin
      lam  = (decay_ff > DECAY_ONE) ? DECAY_ONE : decay_ff;
      rest = DECAY_ONE - lam;
      raw  = sample;
   end

   always_comb begin
      decay_in = decay_ff;
      seed_in  = seed_ff;
      kind_in  = kind_ff;
      if (csr_we) begin
         case (csr_index)
            ewmav_pkg::CSR_DECAY: decay_in = csr_wdata[LAM_W-1:0];
            ewmav_pkg::CSR_SEED:  seed_in  = csr_wdata[EW-1:0];
            ewmav_pkg::CSR_KIND:  kind_in  = csr_wdata[ewmav_pkg::KIND_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cmd.opa)
         ewmav_pkg::OPA_PREV: op_a = p_ff;
         ewmav_pkg::OPA_MAG:  op_a = mag_ff;
         ewmav_pkg::OPA_TLO:  op_a = temp_ff[OW-1:0];
         ewmav_pkg::OPA_THI:  op_a = temp_ff[PW-1:OW];
         default:             op_a = p_ff;
      endcase
      case (cmd.opb)
         ewmav_pkg::OPB_PREV: op_b = p_ff;
         ewmav_pkg::OPB_MAG:  op_b = mag_ff;
         ewmav_pkg::OPB_LAM:  op_b = OW'(lam);
         ewmav_pkg::OPB_REST: op_b = OW'(rest);
         default:             op_b = OW'(lam);
      endcase
   end

   always_comb begin
      p_in    = p_ff;
      mag_in  = mag_ff;
      eos_in  = eos_ff;
      prod_in = prod_ff;
      temp_in = temp_ff;
      acc_in  = acc_ff;
      if (cmd.load) begin
         p_in   = fresh_ff ? seed_ff : prev_ff;
         mag_in = raw[OW-1] ? (OW'(0) - raw) : raw;
         eos_in = end_of_series;
         acc_in = '0;
      end
      if (cmd.mul_en) begin
         prod_in = PW'(op_a) * PW'(op_b);
      end
      case (cmd.wr)
         ewmav_pkg::WR_TEMP:  temp_in = prod_ff;
         ewmav_pkg::WR_ACC0:  acc_in  = acc_ff + ACC_W'(prod_ff);
         ewmav_pkg::WR_ACC32: acc_in  = acc_ff + (ACC_W'(prod_ff) << OW);
         ewmav_pkg::WR_ACCF:  acc_in  = acc_ff + (ACC_W'(prod_ff) << SAMPLE_FRAC_BITS);
         default: ;
      endcase
   end

   always_comb begin
      scaled_d = acc_ff >> DECAY_FRAC_BITS;
      scaled_v = acc_ff >> (SAMPLE_FRAC_BITS + DECAY_FRAC_BITS);
      est_in   = est_ff;
      sat_in   = sat_ff;
      prev_in  = prev_ff;
      fresh_in = fresh_ff;
      if (cmd.finish) begin
         case (kind_ff)
            ewmav_pkg::KIND_STDDEV: begin
               est_in = root;
               sat_in = 1'b0;
            end
            ewmav_pkg::KIND_VARIANCE: begin
               sat_in = |scaled_v[ACC_W-1:EW];
               est_in = sat_in ? '1 : scaled_v[EW-1:0];
            end
            default: begin
               est_in = scaled_d[EW-1:0];
               sat_in = 1'b0;
            end
         endcase
         // clipped value carries into the next item
         prev_in  = est_in;
         fresh_in = eos_ff;
      end
   end

   assign sts.kind      = kind_ff;
   assign sts.root_done = root_done;
   assign estimate      = est_ff;
   assign saturated     = sat_ff;

   a_prev_tracks_est: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.finish) |-> (prev_ff == est_ff))
      else $error("previous estimate differs from delivered word");

   a_sat_is_max: assert property (@(posedge clock) disable iff (reset)
      ($past(cmd.finish) && sat_ff) |-> (&est_ff))
      else $error("saturated word is not full scale");

endmodule

// ===== hdl/ewmav_ctrl.sv =====
module ewmav_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ewmav_pkg::cmd_type  cmd,
   input  ewmav_pkg::sts_type  sts
);

   ewmav_pkg::state_type              state_ff, state_in;
   logic [ewmav_pkg::STEP_W-1:0]      step_ff, step_in;
   logic                              out_valid_ff, out_valid_in;
   ewmav_pkg::uop_type                uop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ewmav_pkg::ST_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      uop       = ewmav_pkg::ewmav_uop(sts.kind, step_ff);
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ewmav_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ewmav_pkg::ST_MUL;
            end
         end
         ewmav_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.opa    = uop.opa;
            cmd.opb    = uop.opb;
            state_in   = ewmav_pkg::ST_WR;
         end
         ewmav_pkg::ST_WR: begin
            cmd.wr = uop.wr;
            if (uop.last) begin
               state_in = (sts.kind == ewmav_pkg::KIND_STDDEV) ?
                          ewmav_pkg::ST_ROOT_GO : ewmav_pkg::ST_DONE;
            end else begin
               step_in  = step_ff + ewmav_pkg::STEP_W'(1);
               state_in = ewmav_pkg::ST_MUL;
            end
         end
         ewmav_pkg::ST_ROOT_GO: begin
            cmd.root_start = 1'b1;
            state_in       = ewmav_pkg::ST_ROOT_WAIT;
         end
         ewmav_pkg::ST_ROOT_WAIT: begin
            if (sts.root_done) begin
               state_in = ewmav_pkg::ST_DONE;
            end
         end
         ewmav_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ewmav_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ewmav_pkg::ST_IDLE;
         end
      endcase
      out_valid_in = cmd.finish | (out_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = out_valid_ff;

   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ewmav_pkg::ST_MUL) |-> (step_ff <= ewmav_pkg::LAST_STEP))
      else $error("multiply step past end of program");

   a_word_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> ($past(state_ff) == ewmav_pkg::ST_DONE))
      else $error("result word raised outside completion");

endmodule

// ===== hdl/ewma_volatility_estimator_top.sv =====
// Each accepted word runs its whole multiply program (and, in standard deviation mode, the root)
// before its result word is registered; the next word is accepted only back in idle, so the
// block never takes a new word before the last one is through.
// One shared 32x32 multiplier computes each product in a multiply and a write state (6, 4 or 2
// products by mode); the root adds a launch state, a bit-serial loop over the 32 result bits and a done flag.
// Synchronous reset restores register defaults, zeroes the previous estimate and reseeds.
module ewma_volatility_estimator_top #(
   parameter int SAMPLE_FRAC_BITS = 16,
   parameter int DECAY_FRAC_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ewmav_req_if.sink                            req_if,
   ewmav_rsp_if.source                          rsp_if,
   input  logic                                 csr_we,
   input  logic [ewmav_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ewmav_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   ewmav_pkg::cmd_type cmd;
   ewmav_pkg::sts_type sts;

   ewmav_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ewmav_datapath #(
      .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS),
      .DECAY_FRAC_BITS  (DECAY_FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .sample        (req_if.sample),
      .end_of_series (req_if.end_of_series),
      .cmd           (cmd),
      .sts           (sts),
      .estimate      (rsp_if.estimate),
      .saturated     (rsp_if.saturated)
   );

endmodule
